// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CHK_SAME_CYCLE(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// Consequent checked from the cycle after the antecedent.
`define CHK_NEXT_CYCLE(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

// File: rtl/csrt_pkg.sv
// Types and constants of the sparse transpose unit.
`timescale 1ns / 1ps
`default_nettype none
package csrt_pkg;

   localparam int ROW_W     = 6;
   localparam int COL_W     = 6;
   localparam int TAG_W     = 8;
   localparam int POS_W     = 9;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_NUM_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_COLS = 1'd1;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic             kind;
      logic [ROW_W-1:0] src_row;
      logic [COL_W-1:0] src_col;
      logic [TAG_W-1:0] tag_value;
      logic             last_entry;
      logic [POS_W-1:0] read_pos;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] row_start;
      logic [ROW_W-1:0] entry_col;
      logic [TAG_W-1:0] entry_tag;
      logic [POS_W-1:0] entry_total;
      logic             load_error;
   } rsp_type;

   // memory strobes and status from the transpose sequencer
   typedef struct packed {
      logic held_re;
      logic cs_re;
      logic cs_we;
      logic out_we;
      logic busy;
      logic done;
   } xpose_ctl_type;

endpackage
`default_nettype wire

// File: rtl/sparse_csr_transpose_unit.sv
// Top level of the sparse pattern transpose unit.
// Load items (kind 0) write one source entry per cycle into the entry store
// while req_stall is low; the entry flagged last_entry starts the transpose
// burst, during which req_stall stays high. The burst walks the stores with
// registered-read memories: it counts the entries of each column, turns the
// counts of columns 0..num_cols into column starts by a prefix sum, then
// scatters each entry to its column fill pointer in the transposed store.
// A read item (kind 1) reads the start and entry stores, then loads the
// result register; a read is taken only when the result register will be
// free. A load is taken also while a result waits. The first load after a
// transpose (or after reset) opens a new load: entry total and column starts
// clear at once (valid bits), and done clears so entry reads return zero
// until the next transpose ends. Rows or columns at or above the configured
// bound and entries beyond MAX_ENTRIES are dropped and set the sticky
// load_error flag.
`timescale 1ns / 1ps
`default_nettype none
module sparse_csr_transpose_unit #(
   parameter int MAX_ENTRIES = 256,
   parameter int MAX_DIM     = 64,
   parameter int TAG_BITS    = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [csrt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [csrt_pkg::CFG_W-1:0]           csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  csrt_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output csrt_pkg::rsp_type                    rsp_data
);
   import csrt_pkg::*;

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int TW = TAG_BITS;
   localparam int HW = ROW_W + COL_W + TW;
   localparam int OW = ROW_W + TW;

   // configuration
   logic [CFG_W-1:0] num_rows_ff, num_cols_ff;
   logic [DW-1:0]    nr_clamp, nc_clamp;

   // load bookkeeping
   logic [CW-1:0]    cnt_ff, cnt_in, cnt_base;
   logic             err_ff, load_open_ff, done_ff;

   // stores
   logic [HW-1:0]    held_mem [MAX_ENTRIES];
   logic [HW-1:0]    held_q;
   logic [CW-1:0]    cs_mem [MAX_DIM + 1];
   logic [CW-1:0]    cs_q, cs_eff;
   logic             cs_qv;
   logic [MAX_DIM:0] cs_vld_ff;
   logic [OW-1:0]    out_mem [MAX_ENTRIES];
   logic [OW-1:0]    out_q;

   // read pipeline and result register
   logic             rd_pend_ff, rd_rs_ok_ff, rd_ent_ok_ff, rd_err_ff;
   logic [CW-1:0]    rd_total_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;

   // handshake decode
   logic             accept, load_acc, read_acc, new_load, drop, start;
   logic [DW-1:0]    cs_raddr;
   logic             cs_re;

   // sequencer
   xpose_ctl_type    xp_ctl;
   logic [AW-1:0]    xp_held_addr, xp_out_addr;
   logic [DW-1:0]    xp_cs_addr;
   logic [CW-1:0]    xp_cs_wdata;
   logic [ROW_W-1:0] xp_out_row;
   logic [TW-1:0]    xp_out_tag;

   assign nr_clamp = (32'(num_rows_ff) > MAX_DIM) ? DW'(MAX_DIM) : DW'(num_rows_ff);
   assign nc_clamp = (32'(num_cols_ff) > MAX_DIM) ? DW'(MAX_DIM) : DW'(num_cols_ff);

   // a read is only taken when the result register is free in the cycle after
   assign req_stall = xp_ctl.busy | rd_pend_ff |
                      ((req_data.kind == KIND_READ) & rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;
   assign load_acc  = accept & (req_data.kind == KIND_LOAD);
   assign read_acc  = accept & (req_data.kind == KIND_READ);
   assign new_load  = load_acc & ~load_open_ff;
   assign cnt_base  = new_load ? '0 : cnt_ff;
   assign drop      = (32'(req_data.src_col) >= 32'(nc_clamp)) ||
                      (32'(req_data.src_row) >= 32'(nr_clamp)) ||
                      (32'(cnt_base) >= MAX_ENTRIES);
   assign start     = load_acc & req_data.last_entry;
   assign cnt_in    = load_acc ? (drop ? cnt_base : cnt_base + CW'(1)) : cnt_ff;

   assign cs_raddr  = xp_ctl.busy ? xp_cs_addr : DW'(req_data.read_pos);
   assign cs_re     = xp_ctl.cs_re | read_acc;
   assign cs_eff    = cs_qv ? cs_q : '0;

   csrt_xpose #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .MAX_DIM     (MAX_DIM),
      .TAG_BITS    (TAG_BITS)
   ) u_xpose (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .count     (cnt_ff),
      .nc        (nc_clamp),
      .held_row  (held_q[HW-1 -: ROW_W]),
      .held_col  (held_q[TW +: COL_W]),
      .held_tag  (held_q[TW-1:0]),
      .cs_rdata  (cs_eff),
      .ctl       (xp_ctl),
      .held_addr (xp_held_addr),
      .cs_addr   (xp_cs_addr),
      .cs_wdata  (xp_cs_wdata),
      .out_addr  (xp_out_addr),
      .out_row   (xp_out_row),
      .out_tag   (xp_out_tag)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff  <= CFG_W'(64);
         num_cols_ff  <= CFG_W'(64);
         cnt_ff       <= '0;
         err_ff       <= 1'b0;
         load_open_ff <= 1'b0;
         done_ff      <= 1'b0;
         cs_vld_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_NUM_ROWS: num_rows_ff <= csr_wdata;
               REG_NUM_COLS: num_cols_ff <= csr_wdata;
               default: ;
            endcase
         end
         cnt_ff <= cnt_in;
         if (load_acc && drop) begin
            err_ff <= 1'b1;
         end
         if (start) begin
            load_open_ff <= 1'b0;
         end else if (new_load) begin
            load_open_ff <= 1'b1;
         end
         if (new_load) begin
            done_ff <= 1'b0;
         end else if (xp_ctl.done) begin
            done_ff <= 1'b1;
         end
         if (new_load) begin
            cs_vld_ff <= '0;
         end else if (xp_ctl.cs_we) begin
            cs_vld_ff[xp_cs_addr] <= 1'b1;
         end
         rd_pend_ff <= read_acc;
         if (rd_pend_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // read item bookkeeping, captured at accept, and the result register
   always_ff @(posedge clock) begin
      if (read_acc) begin
         rd_rs_ok_ff  <= (32'(req_data.read_pos) <= 32'(nc_clamp));
         rd_ent_ok_ff <= done_ff && (32'(req_data.read_pos) < 32'(cnt_ff));
         rd_total_ff  <= cnt_ff;
         rd_err_ff    <= err_ff;
      end
      if (rd_pend_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      rsp_in             = '0;
      rsp_in.row_start   = rd_rs_ok_ff ? POS_W'(cs_eff) : '0;
      rsp_in.entry_col   = rd_ent_ok_ff ? out_q[OW-1 -: ROW_W] : '0;
      rsp_in.entry_tag   = rd_ent_ok_ff ? TAG_W'(out_q[TW-1:0]) : '0;
      rsp_in.entry_total = POS_W'(rd_total_ff);
      rsp_in.load_error  = rd_err_ff;
   end

   // entry store: written by loads, read by the sequencer
   always_ff @(posedge clock) begin
      if (load_acc && !drop) begin
         held_mem[cnt_base[AW-1:0]] <= {req_data.src_row, req_data.src_col,
                                        TW'(req_data.tag_value)};
      end
      if (xp_ctl.held_re) begin
         held_q <= held_mem[xp_held_addr];
      end
   end

   // column start store; an entry without its valid bit reads as zero
   always_ff @(posedge clock) begin
      if (xp_ctl.cs_we) begin
         cs_mem[xp_cs_addr] <= xp_cs_wdata;
      end
      if (cs_re) begin
         cs_q  <= cs_mem[cs_raddr];
         cs_qv <= cs_vld_ff[cs_raddr] & ~(xp_ctl.cs_we & (xp_cs_addr == cs_raddr));
      end
   end

   // transposed entry store
   always_ff @(posedge clock) begin
      if (xp_ctl.out_we) begin
         out_mem[xp_out_addr] <= {xp_out_row, xp_out_tag};
      end
      if (read_acc) begin
         out_q <= out_mem[AW'(req_data.read_pos)];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// File: rtl/csrt_xpose.sv
// Transpose sequencer: column count, prefix sum and scatter over the stores.
`timescale 1ns / 1ps
`default_nettype none
module csrt_xpose #(
   parameter int MAX_ENTRIES = 256,
   parameter int MAX_DIM     = 64,
   parameter int TAG_BITS    = 8
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0]           count,
   input  logic [$clog2(MAX_DIM+1)-1:0]               nc,
   input  logic [csrt_pkg::ROW_W-1:0]                 held_row,
   input  logic [csrt_pkg::COL_W-1:0]                 held_col,
   input  logic [TAG_BITS-1:0]                        held_tag,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0]           cs_rdata,
   output csrt_pkg::xpose_ctl_type                    ctl,
   output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] held_addr,
   output logic [$clog2(MAX_DIM+1)-1:0]               cs_addr,
   output logic [$clog2(MAX_ENTRIES+1)-1:0]           cs_wdata,
   output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] out_addr,
   output logic [csrt_pkg::ROW_W-1:0]                 out_row,
   output logic [TAG_BITS-1:0]                        out_tag
);
   import csrt_pkg::*;

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int FW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_CNT_RD, S_CNT_CS, S_CNT_WR, S_PFX_RD, S_PFX_WR,
      S_SC_RD, S_SC_FP, S_SC_WR
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic [DW-1:0]   pfx_ff, pfx_in;
   logic [CW-1:0]   total_ff, total_in;

   logic [CW-1:0]   fill_mem [MAX_DIM];
   logic [CW-1:0]   fill_q;
   logic            fill_re, fill_we;
   logic [FW-1:0]   fill_addr;
   logic [CW-1:0]   fill_wdata;
   logic            col_ok;

   assign col_ok = (32'(held_col) < 32'(nc));

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      pfx_in     = pfx_ff;
      total_in   = total_ff;
      ctl        = '0;
      ctl.busy   = (state_ff != S_IDLE);
      held_addr  = idx_ff[AW-1:0];
      cs_addr    = DW'(held_col);
      cs_wdata   = cs_rdata + CW'(1);
      out_addr   = fill_q[AW-1:0];
      out_row    = held_row;
      out_tag    = held_tag;
      fill_re    = 1'b0;
      fill_we    = 1'b0;
      fill_addr  = FW'(held_col);
      fill_wdata = fill_q + CW'(1);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               idx_in   = '0;
               state_in = S_CNT_RD;
            end
         end
         S_CNT_RD: begin
            if (idx_ff == count) begin
               pfx_in   = '0;
               total_in = '0;
               state_in = S_PFX_RD;
            end else begin
               ctl.held_re = 1'b1;
               state_in    = S_CNT_CS;
            end
         end
         S_CNT_CS: begin
            if (col_ok) begin
               ctl.cs_re = 1'b1;
               state_in  = S_CNT_WR;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_CNT_RD;
            end
         end
         S_CNT_WR: begin
            ctl.cs_we = 1'b1;
            idx_in    = idx_ff + CW'(1);
            state_in  = S_CNT_RD;
         end
         S_PFX_RD: begin
            ctl.cs_re = 1'b1;
            cs_addr   = pfx_ff;
            state_in  = S_PFX_WR;
         end
         S_PFX_WR: begin
            ctl.cs_we  = 1'b1;
            cs_addr    = pfx_ff;
            cs_wdata   = total_ff;
            fill_we    = (pfx_ff < nc);
            fill_addr  = FW'(pfx_ff);
            fill_wdata = total_ff;
            total_in   = total_ff + cs_rdata;
            if (pfx_ff == nc) begin
               idx_in   = '0;
               state_in = S_SC_RD;
            end else begin
               pfx_in   = pfx_ff + DW'(1);
               state_in = S_PFX_RD;
            end
         end
         S_SC_RD: begin
            if (idx_ff == count) begin
               ctl.done = 1'b1;
               state_in = S_IDLE;
            end else begin
               ctl.held_re = 1'b1;
               state_in    = S_SC_FP;
            end
         end
         S_SC_FP: begin
            if (col_ok) begin
               fill_re  = 1'b1;
               state_in = S_SC_WR;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_SC_RD;
            end
         end
         S_SC_WR: begin
            ctl.out_we = (32'(fill_q) < MAX_ENTRIES);
            fill_we    = 1'b1;
            idx_in     = idx_ff + CW'(1);
            state_in   = S_SC_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         pfx_ff   <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pfx_ff   <= pfx_in;
         total_ff <= total_in;
      end
   end

   // per-column fill pointers
   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_addr] <= fill_wdata;
      end
      if (fill_re) begin
         fill_q <= fill_mem[fill_addr];
      end
   end

endmodule
`default_nettype wire

// File: rtl/csrt_checker.sv
// Port-level checks of the sparse transpose unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module csrt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input csrt_pkg::req_type              req_data,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input csrt_pkg::rsp_type              rsp_data
);
   import csrt_pkg::*;

   logic read_acc, last_acc;

   assign read_acc = req_valid && !req_stall && (req_data.kind == KIND_READ);
   assign last_acc = req_valid && !req_stall && (req_data.kind == KIND_LOAD) &&
                     req_data.last_entry;

   `CHK_NEXT_CYCLE(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `CHK_NEXT_CYCLE(a_read_result, clock, reset, read_acc, ##1 rsp_valid)
   `CHK_NEXT_CYCLE(a_read_blocks, clock, reset, read_acc, req_stall)
   `CHK_NEXT_CYCLE(a_burst_blocks, clock, reset, last_acc, req_stall)

endmodule

bind sparse_csr_transpose_unit csrt_checker u_csrt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
